// ===== rtl/core/tied_pkg.sv =====
package tied_pkg;

    localparam int MaxSeqLenDef = 32;

    localparam logic [7:0] ChEsc   = 8'h1B;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChBs    = 8'h08;
    localparam logic [7:0] ChDel   = 8'h7F;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChTilde = 8'h7E;

    localparam logic [4:0] KeyPrint  = 5'd0;
    localparam logic [4:0] KeyEnter  = 5'd1;
    localparam logic [4:0] KeyTab    = 5'd2;
    localparam logic [4:0] KeyBack   = 5'd3;
    localparam logic [4:0] KeyEscape = 5'd4;
    localparam logic [4:0] KeyUp     = 5'd5;
    localparam logic [4:0] KeyHome   = 5'd9;
    localparam logic [4:0] KeyEnd    = 5'd10;
    localparam logic [4:0] KeyBtab   = 5'd11;
    localparam logic [4:0] KeyIns    = 5'd12;
    localparam logic [4:0] KeyDelete = 5'd13;
    localparam logic [4:0] KeyPgUp   = 5'd14;
    localparam logic [4:0] KeyPgDn   = 5'd15;
    localparam logic [4:0] KeyF1     = 5'd16;
    localparam logic [4:0] KeyF6     = 5'd21;
    localparam logic [4:0] KeyF11    = 5'd26;
    localparam logic [4:0] KeyF12    = 5'd27;

    localparam logic [1:0] MkPress   = 2'd0;
    localparam logic [1:0] MkRelease = 2'd1;
    localparam logic [1:0] MkMove    = 2'd2;
    localparam logic [1:0] MkWheel   = 2'd3;

    localparam logic [2:0] BtnNone  = 3'd0;
    localparam logic [2:0] BtnWUp   = 3'd4;
    localparam logic [2:0] BtnWDown = 3'd5;

    localparam logic [2:0] ModCtrl = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_APPEND, S_DECIDE, S_SCAN1, S_CHECK, S_SCAN2, S_FINISH, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        P_BATCH, P_MOUSE, P_ESC, P_NEWESC, P_UTF8, P_ASCII
    } t_path;

    typedef struct packed {
        logic load;
        logic append;
        logic decide;
        logic scan;
        logic check;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic dec_key;
        logic dec_scan;
        logic scan_last;
        logic chk_ok;
        logic fin_emit;
    } t_sts;

endpackage

// ===== rtl/core/tied_ctrl.sv =====
module tied_ctrl
    import tied_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_APPEND;
            S_APPEND: n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_sts.dec_key) n_state = S_OUT;
                else if (i_sts.dec_scan) n_state = S_SCAN1;
                else n_state = S_IDLE;
            end
            S_SCAN1:  if (i_sts.scan_last) n_state = S_CHECK;
            S_CHECK:  n_state = i_sts.chk_ok ? S_SCAN2 : S_FINISH;
            S_SCAN2:  if (i_sts.scan_last) n_state = S_FINISH;
            S_FINISH: n_state = i_sts.fin_emit ? S_OUT : S_IDLE;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_APPEND: o_cmd.append = 1'b1;
            S_DECIDE: o_cmd.decide = 1'b1;
            S_SCAN1,
            S_SCAN2:  o_cmd.scan   = 1'b1;
            S_CHECK:  o_cmd.check  = 1'b1;
            S_FINISH: o_cmd.finish = 1'b1;
            S_OUT:    o_out_valid  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/tied_dp.sv =====
module tied_dp
    import tied_pkg::*;
#(
    parameter int MAX_SEQ_LEN = MaxSeqLenDef
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_action,
    input  logic [7:0]  i_in_byte,
    output t_sts        o_sts,
    output logic        o_event_kind,
    output logic [4:0]  o_key_code,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_modifiers,
    output logic [1:0]  o_mouse_kind,
    output logic [2:0]  o_mouse_btn,
    output logic [16:0] o_pos_x,
    output logic [16:0] o_pos_y
);

    localparam int Depth = MAX_SEQ_LEN + 1;
    localparam int AW    = $clog2(Depth);
    localparam int LW    = $clog2(Depth + 1);
    localparam logic [LW-1:0] LenMax   = LW'(MAX_SEQ_LEN);
    localparam logic [LW-1:0] LenDepth = LW'(Depth);

    logic [7:0]    r_mem [Depth];
    logic [7:0]    r_q;
    logic [7:0]    r_last;
    logic          r_act;
    logic [7:0]    r_byte;
    logic [LW-1:0] r_len;
    logic          r_esc, r_mouse, r_utf8;
    logic [7:0]    r_b [4];
    t_path         r_path;

    // scan engine
    logic [LW-1:0] r_ra, r_end;
    logic [AW-1:0] r_di;
    logic          r_dv, r_p2;
    logic          r_has_lt, r_has_term, r_rel;
    logic [AW-1:0] r_lt, r_term;
    logic [1:0]    r_field;
    logic [15:0]   r_acc, r_btn, r_mx;
    logic          r_nonempty, r_bad, r_fb;

    // result
    logic          r_kind;
    logic [4:0]    r_key;
    logic [20:0]   r_cp;
    logic [2:0]    r_mods, r_mb;
    logic [1:0]    r_mk;
    logic [16:0]   r_px, r_py;

    // ---- append ----
    logic          app_en, app_reset;
    logic [LW-1:0] app_pos;
    t_path         path;

    always_comb begin
        app_en    = 1'b0;
        app_reset = 1'b0;
        if (r_act) path = P_BATCH;
        else if (r_mouse) path = P_MOUSE;
        else if (r_esc) path = P_ESC;
        else if (r_byte == ChEsc) path = P_NEWESC;
        else if (r_byte[7]) path = P_UTF8;
        else path = P_ASCII;
        unique case (path)
            P_MOUSE, P_ESC: app_en = 1'b1;
            P_NEWESC: begin
                app_en = 1'b1;
                app_reset = 1'b1;
            end
            P_UTF8: begin
                app_en = 1'b1;
                app_reset = !r_utf8;
            end
            default: app_en = 1'b0;
        endcase
        app_pos = app_reset ? '0 : r_len;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && app_en && app_pos < LenDepth) begin
            r_mem[app_pos[AW-1:0]] <= r_byte;
            r_last                 <= r_byte;
        end
        if (i_cmd.scan && r_ra < r_end) begin
            r_q <= r_mem[r_ra[AW-1:0]];
        end
    end

    // ---- decode of the buffered sequence ----
    logic          k_valid, dec_scan, set_mouse, fb;
    logic [4:0]    k_code;
    logic [20:0]   k_cp;
    logic [2:0]    k_mods;
    logic [4:0]    tilde;
    logic [7:0]    fin, ta, tb;
    logic [LW-1:0] n;
    logic          csi, ss3;

    always_comb begin
        ta = r_b[2];
        tb = r_b[3];
        tilde = KeyEscape;
        if (n == LW'(4)) begin
            unique case (ta)
                "1", "7": tilde = KeyHome;
                "2":      tilde = KeyIns;
                "3":      tilde = KeyDelete;
                "4", "8": tilde = KeyEnd;
                "5":      tilde = KeyPgUp;
                "6":      tilde = KeyPgDn;
                default:  tilde = KeyEscape;
            endcase
        end else if (n == LW'(5)) begin
            if (ta == "1" && tb >= "1" && tb <= "5")
                tilde = KeyF1 + 5'(tb - "1");
            else if (ta == "1" && tb >= "7" && tb <= "9")
                tilde = KeyF6 + 5'(tb - "7");
            else if (ta == "2" && (tb == "0" || tb == "1"))
                tilde = KeyF6 + 5'd3 + 5'(tb - "0");
            else if (ta == "2" && tb == "3")
                tilde = KeyF11;
            else if (ta == "2" && tb == "4")
                tilde = KeyF12;
        end
    end

    always_comb begin
        n         = r_len;
        // the input byte on the ASCII path, else the last buffered byte, which stays put once the buffer is full
        fin       = (r_path == P_ASCII) ? r_byte : r_last;
        k_valid   = 1'b0;
        k_code    = KeyPrint;
        k_cp      = '0;
        k_mods    = '0;
        dec_scan  = 1'b0;
        set_mouse = 1'b0;
        fb        = 1'b0;
        ss3 = n >= LW'(3) && r_b[0] == ChEsc && r_b[1] == "O";
        csi = n >= LW'(3) && r_b[0] == ChEsc && r_b[1] == "[";
        unique case (r_path)
            P_BATCH: begin
                k_valid = r_esc && n == LW'(1) && r_b[0] == ChEsc;
                k_code  = KeyEscape;
            end
            P_MOUSE: begin
                fb = n > LenMax;
                if (n >= LW'(6)) dec_scan = 1'b1;
                else begin
                    k_valid = fb;
                    k_code  = KeyEscape;
                end
            end
            P_ESC: begin
                k_code = KeyEscape;
                if (ss3) begin
                    k_valid = 1'b1;
                    if (r_b[2] >= "P" && r_b[2] <= "S")
                        k_code = KeyF1 + 5'(r_b[2] - "P");
                end else if (csi && n == LW'(3) && fin >= "A" && fin <= "D") begin
                    k_valid = 1'b1;
                    k_code  = KeyUp + 5'(fin - "A");
                end else if (csi && n == LW'(3) && fin == "H") begin
                    k_valid = 1'b1;
                    k_code  = KeyHome;
                end else if (csi && n == LW'(3) && fin == "F") begin
                    k_valid = 1'b1;
                    k_code  = KeyEnd;
                end else if (csi && n == LW'(3) && fin == "Z") begin
                    k_valid = 1'b1;
                    k_code  = KeyBtab;
                end else if (csi && fin == ChTilde) begin
                    k_valid = 1'b1;
                    k_code  = tilde;
                end else if (csi && n >= LW'(6) && r_b[2] == ChLt &&
                             (fin == "M" || fin == "m")) begin
                    dec_scan = 1'b1;
                end else if (csi && n >= LW'(6) && r_b[2] == ChLt && n < LW'(16)) begin
                    set_mouse = 1'b1;
                end else begin
                    k_valid = n > LenMax;
                end
            end
            P_NEWESC: k_valid = 1'b0;
            P_UTF8: begin
                if (r_b[0][7:5] == 3'b110) begin
                    k_valid = n >= LW'(2);
                    k_cp    = {10'd0, r_b[0][4:0], r_b[1][5:0]};
                end else if (r_b[0][7:4] == 4'b1110) begin
                    k_valid = n >= LW'(3);
                    k_cp    = {5'd0, r_b[0][3:0], r_b[1][5:0], r_b[2][5:0]};
                end else if (r_b[0][7:3] == 5'b11110) begin
                    k_valid = n >= LW'(4);
                    k_cp    = {r_b[0][2:0], r_b[1][5:0], r_b[2][5:0], r_b[3][5:0]};
                end else begin
                    k_valid = 1'b1;
                    k_cp    = 21'h00FFFD;
                end
            end
            P_ASCII: begin
                k_valid = 1'b1;
                if (fin == ChCr || fin == ChLf) k_code = KeyEnter;
                else if (fin == ChTab) k_code = KeyTab;
                else if (fin == ChDel || fin == ChBs) k_code = KeyBack;
                else if (fin < 8'h20) begin
                    k_cp   = 21'(fin) + 21'h60;
                    k_mods = ModCtrl;
                end else k_cp = 21'(fin);
            end
            default: k_valid = 1'b0;
        endcase
    end

    // ---- scan step ----
    logic          s_issue;
    logic [19:0]   s_mul;
    logic [15:0]   s_next;
    logic          s_digit;
    logic          mouse_ok;
    logic [1:0]    m_code, m_kind;
    logic [2:0]    m_btn, m_mods;

    always_comb begin
        s_issue = r_ra < r_end;
        s_digit = r_q >= "0" && r_q <= "9";
        s_mul   = {1'b0, r_acc, 3'd0} + {3'd0, r_acc, 1'b0} + 20'(r_q - "0");
        s_next  = (s_mul > 20'd65535) ? 16'hFFFF : s_mul[15:0];
        mouse_ok = r_p2 && !r_bad && r_field == 2'd2 && r_nonempty;
        m_code = r_btn[1:0];
        m_btn  = (m_code != 2'd3) ? 3'(m_code) + 3'd1 : BtnNone;
        m_kind = MkPress;
        if (r_btn[6]) begin
            m_kind = MkWheel;
            m_btn  = (m_code == 2'd0) ? BtnWUp : (m_code == 2'd1) ? BtnWDown : BtnNone;
        end else if (r_rel) begin
            m_kind = MkRelease;
        end else if (r_btn[5]) begin
            m_kind = MkMove;
            m_btn  = BtnNone;
        end
        m_mods = {r_btn[4], r_btn[3], r_btn[2]};
    end

    assign o_sts.dec_key   = k_valid;
    assign o_sts.dec_scan  = dec_scan;
    assign o_sts.scan_last = r_dv && (LW'(r_di) + LW'(1) == r_end);
    assign o_sts.chk_ok    = r_has_lt && r_has_term && r_term > r_lt + AW'(1);
    assign o_sts.fin_emit  = mouse_ok || r_fb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_byte <= i_in_byte;
        end
        if (i_cmd.scan) begin
            r_dv <= s_issue;
            r_di <= r_ra[AW-1:0];
            if (s_issue) r_ra <= r_ra + LW'(1);
            if (r_dv && !r_p2) begin
                if (r_q == ChLt && !r_has_lt) begin
                    r_has_lt <= 1'b1;
                    r_lt     <= r_di;
                end
                if (r_q == "M" || r_q == "m") begin
                    r_has_term <= 1'b1;
                    r_term     <= r_di;
                    r_rel      <= r_q == "m";
                end
            end
            if (r_dv && r_p2) begin
                if (r_q == ChSemi && r_field != 2'd2) begin
                    if (!r_nonempty) r_bad <= 1'b1;
                    if (r_field == 2'd0) r_btn <= r_acc;
                    else r_mx <= r_acc;
                    r_field    <= r_field + 2'd1;
                    r_acc      <= '0;
                    r_nonempty <= 1'b0;
                end else if (s_digit) begin
                    r_acc      <= s_next;
                    r_nonempty <= 1'b1;
                end else begin
                    r_bad <= 1'b1;
                end
            end
        end
        if (i_cmd.decide) begin
            r_ra       <= '0;
            r_end      <= r_len;
            r_dv       <= 1'b0;
            r_p2       <= 1'b0;
            r_has_lt   <= 1'b0;
            r_has_term <= 1'b0;
            r_fb       <= fb;
        end
        if (i_cmd.check) begin
            r_ra       <= LW'(r_lt) + LW'(1);
            r_end      <= LW'(r_term);
            r_dv       <= 1'b0;
            r_p2       <= o_sts.chk_ok;
            r_field    <= '0;
            r_acc      <= '0;
            r_nonempty <= 1'b0;
            r_bad      <= 1'b0;
        end
        if (i_cmd.decide && k_valid) begin
            r_kind <= 1'b0;
            r_key  <= k_code;
            r_cp   <= k_cp;
            r_mods <= k_mods;
            r_mk   <= '0;
            r_mb   <= '0;
            r_px   <= '0;
            r_py   <= '0;
        end
        if (i_cmd.finish) begin
            if (mouse_ok) begin
                r_kind <= 1'b1;
                r_key  <= KeyPrint;
                r_cp   <= '0;
                r_mods <= m_mods;
                r_mk   <= m_kind;
                r_mb   <= m_btn;
                r_px   <= {1'b0, r_mx} - 17'd1;
                r_py   <= {1'b0, r_acc} - 17'd1;
            end else begin
                r_kind <= 1'b0;
                r_key  <= KeyEscape;
                r_cp   <= '0;
                r_mods <= '0;
                r_mk   <= '0;
                r_mb   <= '0;
                r_px   <= '0;
                r_py   <= '0;
            end
        end
        if (i_cmd.append && app_en && app_pos < LenDepth && app_pos < LW'(4)) begin
            r_b[app_pos[1:0]] <= r_byte;
        end
    end

    // control state of the sequence buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_esc   <= 1'b0;
            r_mouse <= 1'b0;
            r_utf8  <= 1'b0;
            r_path  <= P_BATCH;
        end else begin
            if (i_cmd.append) begin
                r_path <= path;
                if (app_en) r_len <= (app_pos < LenDepth) ? app_pos + LW'(1) : app_pos;
                if (path == P_NEWESC) r_esc <= 1'b1;
                if (path == P_UTF8) r_utf8 <= 1'b1;
                if (path == P_ASCII) r_utf8 <= 1'b0;
            end
            if (i_cmd.decide && set_mouse) r_mouse <= 1'b1;
            if ((i_cmd.decide && k_valid) || (i_cmd.finish && o_sts.fin_emit)) begin
                r_len   <= '0;
                r_esc   <= 1'b0;
                r_mouse <= 1'b0;
                r_utf8  <= 1'b0;
            end
        end
    end

    assign o_event_kind   = r_kind;
    assign o_key_code     = r_key;
    assign o_code_point   = r_cp;
    assign o_modifiers    = r_mods;
    assign o_mouse_kind   = r_mk;
    assign o_mouse_btn    = r_mb;
    assign o_pos_x        = r_px;
    assign o_pos_y        = r_py;

endmodule

// ===== rtl/core/terminal_input_event_decoder.sv =====
// Plain keys and UTF-8 need no scan; an SGR mouse report adds a pass over the
// sequence buffer through its single read port and, once '<' and a final with
// bytes between them are found, a second pass over the bytes between '<' and the final.
// One request at a time; the next is taken once the last is done and its
// result, if any, has been taken.
// Reset (synchronous, i_rst_n low): buffer empty, all modes off, no result pending.
module terminal_input_event_decoder
    import tied_pkg::*;
#(
    parameter int MAX_SEQ_LEN = MaxSeqLenDef
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // in_byte[7:0]
    input  logic        i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // key_code[4:0], code_point[25:5], modifiers[28:26], mouse_kind[30:29],
    // button[33:31], pos_x[50:34], pos_y[67:51], zero[71:68]
    output logic [71:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser   // event_kind
);

    t_cmd        cmd;
    t_sts        sts;
    logic        ev_kind;
    logic [4:0]  key;
    logic [20:0] cp;
    logic [2:0]  mods, mb;
    logic [1:0]  mk;
    logic [16:0] px, py;

    tied_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    tied_dp #(.MAX_SEQ_LEN(MAX_SEQ_LEN)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_s_axis_tuser),
        .i_in_byte      (i_s_axis_tdata),
        .o_sts          (sts),
        .o_event_kind   (ev_kind),
        .o_key_code     (key),
        .o_code_point   (cp),
        .o_modifiers    (mods),
        .o_mouse_kind   (mk),
        .o_mouse_btn    (mb),
        .o_pos_x        (px),
        .o_pos_y        (py)
    );

    assign o_m_axis_tdata = {4'd0, py, px, mb, mk, mods, cp, key};
    assign o_m_axis_tuser = ev_kind;

endmodule
